FILE: rtl/gzhp_pkg.sv
package gzhp_pkg;

  // Parser phases, in header order
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_FIXED   = 4'd1,
    PH_XLEN0   = 4'd2,
    PH_XLEN1   = 4'd3,
    PH_XDATA   = 4'd4,
    PH_NAME    = 4'd5,
    PH_COMMENT = 4'd6,
    PH_HCRC0   = 4'd7,
    PH_HCRC1   = 4'd8,
    PH_DONE    = 4'd9
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_METHOD = 3'd3,
    ST_BAD_HCRC   = 3'd4
  } status_t;

  // FLG bit positions
  localparam int unsigned FL_HCRC_BIT    = 1;
  localparam int unsigned FL_EXTRA_BIT   = 2;
  localparam int unsigned FL_NAME_BIT    = 3;
  localparam int unsigned FL_COMMENT_BIT = 4;

  localparam logic [7:0]  GZ_ID1         = 8'h1F;
  localparam logic [7:0]  GZ_ID2         = 8'h8B;
  localparam logic [7:0]  GZ_CM_DEFLATE  = 8'h08;
  localparam logic [31:0] CRC32_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC32_INIT     = 32'hFFFFFFFF;

  localparam int unsigned OFS_BITS   = 24;
  localparam int unsigned TDATA_BITS = 136;

  // Reflected CRC-32 update by one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // First optional section after the given phase whose flag is set
  function automatic phase_t next_section(input phase_t after, input logic [7:0] flags);
    phase_t ph;
    if (after < PH_XLEN0 && flags[FL_EXTRA_BIT]) begin
      ph = PH_XLEN0;
    end else if (after < PH_NAME && flags[FL_NAME_BIT]) begin
      ph = PH_NAME;
    end else if (after < PH_COMMENT && flags[FL_COMMENT_BIT]) begin
      ph = PH_COMMENT;
    end else if (after < PH_HCRC0 && flags[FL_HCRC_BIT]) begin
      ph = PH_HCRC0;
    end else begin
      ph = PH_DONE;
    end
    return ph;
  endfunction

endpackage

FILE: rtl/gzip_header_parser_core.sv
// gzip (RFC 1952) header parser. Feed the stream one byte per request on the in_ channel,
// with in_tuser set on the first byte of a header and in_tlast on the final byte of the
// buffer. One result request follows per header not cut off by a new first byte: on
// completion, on a bad magic or method (reported after the tenth byte), on a header CRC16
// mismatch, or as incomplete when the buffer ends early. Bytes arriving with no header
// open are dropped. The block takes one byte every cycle, unless a result is still
// waiting when the next header closes. Each result is registered. The rate is set by the
// byte-wide CRC-32 update, done combinationally in the processing stage. Offsets and
// the header size count from the first byte and saturate at 2^POS_BITS - 1.
module gzip_header_parser_core
  import gzhp_pkg::*;
#(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // byte_in
  input  logic                  in_tuser,   // first
  input  logic                  in_tlast,   // last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // flag_bits[7:0], mod_time[39:8], extra_flags[47:40], os_code[55:48],
  // hdr_len[79:56], name_present[80], name_offset[104:81],
  // comment_present[105], comment_offset[129:106], zero pad[135:130]
  output logic [TDATA_BITS-1:0] out_tdata,
  output logic [2:0]            out_tuser   // status
);

  // Input stage
  logic       s_valid_r;
  logic [7:0] s_byte_r;
  logic       s_first_r;
  logic       s_last_r;

  // Parser state
  phase_t              phase_r, phase_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]         xrem_r, xrem_nxt;
  logic [31:0]         crc_r, crc_nxt;
  logic                magic_ok_r, magic_ok_nxt;
  logic                method_bad_r, method_bad_nxt;
  logic [7:0]          flags_r, flags_nxt;
  logic [31:0]         mtime_r, mtime_nxt;
  logic [7:0]          xfl_r, xfl_nxt;
  logic [7:0]          os_r, os_nxt;
  logic [POS_BITS-1:0] name_start_r, name_start_nxt;
  logic [POS_BITS-1:0] cmt_start_r, cmt_start_nxt;
  logic [7:0]          hcrc_lo_r, hcrc_lo_nxt;
  logic [15:0]         crc_snap_r, crc_snap_nxt;

  // Effective state for this byte (first restarts from reset values, phase at PH_FIXED)
  phase_t              ph;
  phase_t              ph_tr;
  logic [POS_BITS-1:0] pos_e;
  logic                emit;
  status_t             status;

  // Result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [TDATA_BITS-1:0] out_data_r;
  logic [TDATA_BITS-1:0] res_data;
  logic                np, cp;
  logic                out_free, go;

  assign out_free  = !out_valid_r || out_tready;
  assign go        = s_valid_r && (!emit || out_free);
  assign in_tready = !s_valid_r || go;

  // Next-state logic: process the staged byte
  always_comb begin
    logic [31:0] crc_e;
    logic [15:0] xrem_dec;
    phase_t      adv;
    ph             = s_first_r ? PH_FIXED : phase_r;
    pos_e          = s_first_r ? '0 : pos_r;
    crc_e          = s_first_r ? CRC32_INIT : crc_r;
    xrem_nxt       = s_first_r ? 16'd0 : xrem_r;
    magic_ok_nxt   = s_first_r ? 1'b1 : magic_ok_r;
    method_bad_nxt = s_first_r ? 1'b0 : method_bad_r;
    flags_nxt      = s_first_r ? 8'd0 : flags_r;
    mtime_nxt      = s_first_r ? 32'd0 : mtime_r;
    xfl_nxt        = s_first_r ? 8'd0 : xfl_r;
    os_nxt         = s_first_r ? 8'd0 : os_r;
    name_start_nxt = s_first_r ? '0 : name_start_r;
    cmt_start_nxt  = s_first_r ? '0 : cmt_start_r;
    hcrc_lo_nxt    = s_first_r ? 8'd0 : hcrc_lo_r;
    crc_snap_nxt   = s_first_r ? 16'd0 : crc_snap_r;
    ph_tr          = ph;
    emit           = 1'b0;
    status         = ST_OK;
    xrem_dec       = xrem_nxt - 16'd1;
    adv            = next_section(ph, flags_nxt);

    // Advance the position, saturating
    pos_nxt = (pos_e != '1) ? pos_e + POS_BITS'(1) : pos_e;
    crc_nxt = (ph == PH_HCRC0 || ph == PH_HCRC1) ? crc_e : crc32_byte(crc_e, s_byte_r);

    case (ph)
      PH_FIXED: begin
        if (pos_e == POS_BITS'(0) && s_byte_r != GZ_ID1) begin
          magic_ok_nxt = 1'b0;
        end else if (pos_e == POS_BITS'(1) && s_byte_r != GZ_ID2) begin
          magic_ok_nxt = 1'b0;
        end else if (pos_e == POS_BITS'(2)) begin
          method_bad_nxt = (s_byte_r != GZ_CM_DEFLATE);
        end else if (pos_e == POS_BITS'(3)) begin
          flags_nxt = s_byte_r;
        end else if (pos_e == POS_BITS'(4)) begin
          mtime_nxt[7:0] = s_byte_r;
        end else if (pos_e == POS_BITS'(5)) begin
          mtime_nxt[15:8] = s_byte_r;
        end else if (pos_e == POS_BITS'(6)) begin
          mtime_nxt[23:16] = s_byte_r;
        end else if (pos_e == POS_BITS'(7)) begin
          mtime_nxt[31:24] = s_byte_r;
        end else if (pos_e == POS_BITS'(8)) begin
          xfl_nxt = s_byte_r;
        end else if (pos_e == POS_BITS'(9)) begin
          os_nxt = s_byte_r;
          if (!magic_ok_nxt) begin
            emit   = 1'b1;
            status = ST_BAD_MAGIC;
          end else if (method_bad_nxt) begin
            emit   = 1'b1;
            status = ST_BAD_METHOD;
          end else begin
            ph_tr = adv;
          end
        end
      end
      PH_XLEN0: begin
        xrem_nxt = {8'd0, s_byte_r};
        ph_tr    = PH_XLEN1;
      end
      PH_XLEN1: begin
        xrem_nxt = {s_byte_r, xrem_nxt[7:0]};
        ph_tr    = (xrem_nxt == 16'd0) ? next_section(PH_XDATA, flags_nxt) : PH_XDATA;
      end
      PH_XDATA: begin
        xrem_nxt = xrem_dec;
        if (xrem_dec == 16'd0) begin
          ph_tr = next_section(PH_XDATA, flags_nxt);
        end
      end
      PH_NAME: begin
        if (s_byte_r == 8'd0) begin
          ph_tr = next_section(PH_NAME, flags_nxt);
        end
      end
      PH_COMMENT: begin
        if (s_byte_r == 8'd0) begin
          ph_tr = next_section(PH_COMMENT, flags_nxt);
        end
      end
      PH_HCRC0: begin
        hcrc_lo_nxt = s_byte_r;
        ph_tr       = PH_HCRC1;
      end
      PH_HCRC1: begin
        emit   = 1'b1;
        status = ({s_byte_r, hcrc_lo_nxt} == crc_snap_nxt) ? ST_OK : ST_BAD_HCRC;
      end
      default: begin
        ph_tr = PH_IDLE;
      end
    endcase

    // Record section starts, and the CRC snapshot for the header CRC, on entry
    if (ph_tr != ph) begin
      if (ph_tr == PH_NAME) begin
        name_start_nxt = pos_nxt;
      end else if (ph_tr == PH_COMMENT) begin
        cmt_start_nxt = pos_nxt;
      end else if (ph_tr == PH_HCRC0) begin
        crc_snap_nxt = ~crc_nxt[15:0];
      end
    end

    // Close the header on completion, or on the last byte of the buffer
    if (!emit && ph != PH_IDLE) begin
      if (ph_tr == PH_DONE) begin
        emit   = 1'b1;
        status = ST_OK;
      end else if (s_last_r) begin
        emit   = 1'b1;
        status = ST_INCOMPLETE;
      end
    end

    phase_nxt = emit ? PH_IDLE : ph_tr;
  end

  // Output logic: assemble the result from the updated state
  always_comb begin
    np = flags_nxt[FL_NAME_BIT] && (ph_tr > PH_NAME);
    cp = flags_nxt[FL_COMMENT_BIT] && (ph_tr > PH_COMMENT);
    res_data = '0;
    res_data[7:0]     = flags_nxt;
    res_data[39:8]    = mtime_nxt;
    res_data[47:40]   = xfl_nxt;
    res_data[55:48]   = os_nxt;
    res_data[79:56]   = (status == ST_OK) ? OFS_BITS'(pos_nxt) : '0;
    res_data[80]      = np;
    res_data[104:81]  = np ? OFS_BITS'(name_start_nxt) : '0;
    res_data[105]     = cp;
    res_data[129:106] = cp ? OFS_BITS'(cmt_start_nxt) : '0;
  end

  // Input stage: hold the byte until the processing stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s_valid_r <= 1'b1;
    end else if (go) begin
      s_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s_byte_r  <= in_tdata;
      s_first_r <= in_tuser;
      s_last_r  <= in_tlast;
    end
  end

  // Parser state: advance when the staged byte is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pos_r        <= '0;
      xrem_r       <= 16'd0;
      crc_r        <= CRC32_INIT;
      magic_ok_r   <= 1'b1;
      method_bad_r <= 1'b0;
      flags_r      <= 8'd0;
      mtime_r      <= 32'd0;
      xfl_r        <= 8'd0;
      os_r         <= 8'd0;
      name_start_r <= '0;
      cmt_start_r  <= '0;
      hcrc_lo_r    <= 8'd0;
      crc_snap_r   <= 16'd0;
    end else if (go && (s_first_r || phase_r != PH_IDLE)) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      xrem_r       <= xrem_nxt;
      crc_r        <= crc_nxt;
      magic_ok_r   <= magic_ok_nxt;
      method_bad_r <= method_bad_nxt;
      flags_r      <= flags_nxt;
      mtime_r      <= mtime_nxt;
      xfl_r        <= xfl_nxt;
      os_r         <= os_nxt;
      name_start_r <= name_start_nxt;
      cmt_start_r  <= cmt_start_nxt;
      hcrc_lo_r    <= hcrc_lo_nxt;
      crc_snap_r   <= crc_snap_nxt;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (go && emit) begin
      out_status_r <= status;
      out_data_r   <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: dv/gzhp_tb_pkg.sv
package gzhp_tb_pkg;
  import gzhp_pkg::*;

  // One parsed-header result, field by field
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  flg;
    logic [31:0] mtime;
    logic [7:0]  xfl;
    logic [7:0]  os;
    logic [23:0] hdr_size;
    logic        name_p;
    logic [23:0] name_ofs;
    logic        comment_p;
    logic [23:0] comment_ofs;
  } hdr_info_t;

  localparam logic [23:0] POS_LIMIT = 24'hFFFFFF;

  // Reflected CRC-32, fed one data bit at a time, LSB first
  function automatic logic [31:0] crc32_next(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
    end
    return c;
  endfunction

  class gz_header_scoreboard;
    phase_t      ph;
    logic [23:0] pos;
    logic [15:0] xrem;
    logic [31:0] crc;
    bit          magic_ok;
    bit          method_bad;
    logic [7:0]  flg;
    logic [31:0] mtime;
    logic [7:0]  xfl;
    logic [7:0]  os;
    logic [23:0] name_ofs;
    logic [23:0] comment_ofs;
    logic [7:0]  crc_lo;
    logic [15:0] crc_snap;

    hdr_info_t   expected_q[$];
    int unsigned n_fail;
    int unsigned n_checked;
    int unsigned status_seen[5];

    function new();
      clear();
      ph        = PH_IDLE;
      n_fail    = 0;
      n_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Return the header state to its power-up values
    function void clear();
      ph          = PH_IDLE;
      pos         = '0;
      xrem        = '0;
      crc         = CRC32_INIT;
      magic_ok    = 1'b1;
      method_bad  = 1'b0;
      flg         = '0;
      mtime       = '0;
      xfl         = '0;
      os          = '0;
      name_ofs    = '0;
      comment_ofs = '0;
      crc_lo      = '0;
      crc_snap    = '0;
    endfunction

    function void log_fail(string msg);
      n_fail++;
      if (n_fail <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Enter a section, latching the offset or CRC snapshot it needs
    function void open_section(phase_t nxt);
      ph = nxt;
      case (nxt)
        PH_NAME:    name_ofs = pos;
        PH_COMMENT: comment_ofs = pos;
        PH_HCRC0:   crc_snap = ~crc[15:0];
        default:    ;
      endcase
    endfunction

    // Move on to the next optional section flagged in FLG
    function void skip_to_next(phase_t after);
      if (after < PH_XLEN0 && flg[FL_EXTRA_BIT]) begin
        open_section(PH_XLEN0);
      end else if (after < PH_NAME && flg[FL_NAME_BIT]) begin
        open_section(PH_NAME);
      end else if (after < PH_COMMENT && flg[FL_COMMENT_BIT]) begin
        open_section(PH_COMMENT);
      end else if (after < PH_HCRC0 && flg[FL_HCRC_BIT]) begin
        open_section(PH_HCRC0);
      end else begin
        open_section(PH_DONE);
      end
    endfunction

    // Queue the result for the header in progress and go idle
    function void close_header(status_t st);
      hdr_info_t e;
      e.status      = st;
      e.flg         = flg;
      e.mtime       = mtime;
      e.xfl         = xfl;
      e.os          = os;
      e.hdr_size    = (st == ST_OK) ? pos : '0;
      e.name_p      = flg[FL_NAME_BIT] && (ph > PH_NAME);
      e.name_ofs    = e.name_p ? name_ofs : '0;
      e.comment_p   = flg[FL_COMMENT_BIT] && (ph > PH_COMMENT);
      e.comment_ofs = e.comment_p ? comment_ofs : '0;
      expected_q.push_back(e);
      ph = PH_IDLE;
    endfunction

    // Advance the header state by one accepted byte request
    function void note_input(logic [7:0] b, logic first, logic last);
      logic [23:0] at;
      if (first) begin
        clear();
        ph = PH_FIXED;
      end
      if (ph == PH_IDLE) return;

      at = pos;
      if (pos != POS_LIMIT) pos = pos + 1'b1;
      if (ph != PH_HCRC0 && ph != PH_HCRC1) crc = crc32_next(crc, b);

      case (ph)
        PH_FIXED: begin
          if (at == 0) begin
            if (b != GZ_ID1) magic_ok = 1'b0;
          end else if (at == 1) begin
            if (b != GZ_ID2) magic_ok = 1'b0;
          end else if (at == 2) begin
            method_bad = (b != GZ_CM_DEFLATE);
          end else if (at == 3) begin
            flg = b;
          end else if (at >= 4 && at <= 7) begin
            mtime[at[1:0]*8 +: 8] = b;
          end else if (at == 8) begin
            xfl = b;
          end else if (at == 9) begin
            os = b;
            // magic errors win over a bad method, and both ignore last
            if (!magic_ok) begin
              close_header(ST_BAD_MAGIC);
              return;
            end
            if (method_bad) begin
              close_header(ST_BAD_METHOD);
              return;
            end
            skip_to_next(PH_FIXED);
          end
        end
        PH_XLEN0: begin
          xrem = {8'h00, b};
          open_section(PH_XLEN1);
        end
        PH_XLEN1: begin
          xrem[15:8] = b;
          if (xrem == 0) skip_to_next(PH_XDATA);
          else open_section(PH_XDATA);
        end
        PH_XDATA: begin
          xrem = xrem - 1'b1;
          if (xrem == 0) skip_to_next(PH_XDATA);
        end
        PH_NAME: begin
          if (b == 8'h00) skip_to_next(PH_NAME);
        end
        PH_COMMENT: begin
          if (b == 8'h00) skip_to_next(PH_COMMENT);
        end
        PH_HCRC0: begin
          crc_lo = b;
          open_section(PH_HCRC1);
        end
        PH_HCRC1: begin
          close_header(({b, crc_lo} == crc_snap) ? ST_OK : ST_BAD_HCRC);
          return;
        end
        default: begin
          ph = PH_IDLE;
          return;
        end
      endcase

      // completion takes precedence over the end of the buffer
      if (ph == PH_DONE) close_header(ST_OK);
      else if (last) close_header(ST_INCOMPLETE);
    endfunction

    function void field_check(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        log_fail($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                           n_checked, field, want, got));
      end
    endfunction

    // Compare one result request with the oldest expected header
    function void check_result(logic [TDATA_BITS-1:0] d, logic [2:0] st);
      hdr_info_t e;
      if (expected_q.size() == 0) begin
        log_fail($sformatf("result with no header pending, status %0d", st));
        return;
      end
      e = expected_q.pop_front();
      field_check("status", e.status, st);
      field_check("flag_bits", e.flg, d[7:0]);
      field_check("mod_time", e.mtime, d[39:8]);
      field_check("extra_flags", e.xfl, d[47:40]);
      field_check("os_code", e.os, d[55:48]);
      field_check("hdr_len", e.hdr_size, d[79:56]);
      field_check("name_present", e.name_p, d[80]);
      field_check("name_offset", e.name_ofs, d[104:81]);
      field_check("comment_present", e.comment_p, d[105]);
      field_check("comment_offset", e.comment_ofs, d[129:106]);
      if (e.status < 5) status_seen[e.status]++;
      n_checked++;
    endfunction

    // Flag any header whose result never came
    function void drain_check();
      if (expected_q.size() != 0) begin
        log_fail($sformatf("%0d header results never arrived", expected_q.size()));
      end
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
module tb_top;
  import gzhp_pkg::*;
  import gzhp_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_BYTES = 460;

  typedef enum {
    HK_GOOD,
    HK_BAD_MAGIC,
    HK_BAD_METHOD,
    HK_SHORT,
    HK_RESTART,
    HK_BAD_HCRC
  } hdr_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // byte_in
  logic                  in_tuser;   // first
  logic                  in_tlast;   // last
  logic                  out_tvalid;
  logic                  out_tready;
  // flag_bits, mod_time, extra_flags, os_code, hdr_len, name_present,
  // name_offset, comment_present, comment_offset, zero pad
  logic [TDATA_BITS-1:0] out_tdata;
  logic [2:0]            out_tuser;  // status

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;
  int unsigned bytes_sent;
  int unsigned headers_sent;
  int unsigned cycle_cnt;

  gz_header_scoreboard sb = new();

  gzip_header_parser_core #(
    .POS_BITS(24)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL gzip_header_parser_core");
      $finish;
    end
  end

  // Observe both channels with the values sampled at the edge
  always @(posedge clk) begin
    if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser, in_tlast);
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Result side: random stalls, or a long hold-off when asked
  initial begin
    hold_len = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one byte request, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Build a header of the given kind with random content and send it
  task automatic send_header(input hdr_kind_t kind);
    logic [7:0]  hdr[$];
    logic [7:0]  flg;
    logic [31:0] c;
    int unsigned xlen;
    int unsigned n;
    int unsigned cut;
    int unsigned idx;
    bit          end_mark;

    flg = 8'($urandom());
    if (kind == HK_BAD_HCRC) flg[FL_HCRC_BIT] = 1'b1;
    hdr.push_back(GZ_ID1);
    hdr.push_back(GZ_ID2);
    hdr.push_back(GZ_CM_DEFLATE);
    hdr.push_back(flg);
    repeat (6) hdr.push_back(8'($urandom()));

    // corrupt the magic, sometimes the method as well
    if (kind == HK_BAD_MAGIC) begin
      idx = $urandom_range(1);
      hdr[idx] = hdr[idx] ^ 8'($urandom_range(1, 255));
      if ($urandom_range(1)) hdr[2] = GZ_CM_DEFLATE ^ 8'($urandom_range(1, 255));
    end
    if (kind == HK_BAD_METHOD) hdr[2] = GZ_CM_DEFLATE ^ 8'($urandom_range(1, 255));

    // extra field: mostly short, now and then a few hundred bytes
    if (flg[FL_EXTRA_BIT]) begin
      xlen = ($urandom_range(19) == 0) ? $urandom_range(13, 400) : $urandom_range(0, 12);
      hdr.push_back(xlen[7:0]);
      hdr.push_back(xlen[15:8]);
      repeat (xlen) hdr.push_back(8'($urandom()));
    end
    if (flg[FL_NAME_BIT]) begin
      n = $urandom_range(0, 8);
      repeat (n) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end
    if (flg[FL_COMMENT_BIT]) begin
      n = $urandom_range(0, 8);
      repeat (n) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'h00);
    end

    // header CRC16 over everything so far, broken on request
    if (flg[FL_HCRC_BIT]) begin
      c = CRC32_INIT;
      foreach (hdr[i]) c = crc32_next(c, hdr[i]);
      c = ~c;
      hdr.push_back(c[7:0]);
      hdr.push_back(c[15:8]);
      if (kind == HK_BAD_HCRC) begin
        idx = hdr.size() - 1 - $urandom_range(1);
        hdr[idx] = hdr[idx] ^ (8'h01 << $urandom_range(7));
      end
    end

    // cut short for truncated or abandoned headers
    if (kind == HK_SHORT || kind == HK_RESTART) cut = $urandom_range(hdr.size() - 2);
    else cut = hdr.size() - 1;
    end_mark = (kind == HK_SHORT) || (kind != HK_RESTART && $urandom_range(1) == 1);

    for (int i = 0; i <= cut; i++) begin
      send_byte(hdr[i], i == 0, end_mark && (i == cut));
    end
    headers_sent++;
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned r;
    hdr_kind_t   kind;

    idle_pct     = 0;
    stall_pct    = 0;
    bytes_sent   = 0;
    headers_sent = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray byte while idle, carrying last: dropped
    send_byte(8'hA5, 1'b0, 1'b1);
    // buffer ends on the very first byte
    send_byte(GZ_ID1, 1'b1, 1'b1);
    // wrong magic but buffer too short: incomplete
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // header abandoned by a new first byte
    send_byte(GZ_ID1, 1'b1, 1'b0);
    send_byte(GZ_ID2, 1'b0, 1'b0);
    // magic and method both wrong, all-ones fields: bad magic reported
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h07, 1'b0, 1'b0);
    repeat (6) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // minimal header, last on the completing byte
    send_byte(GZ_ID1, 1'b1, 1'b0);
    send_byte(GZ_ID2, 1'b0, 1'b0);
    send_byte(GZ_CM_DEFLATE, 1'b0, 1'b0);
    repeat (6) send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b1);

    // random headers under four idle and stall profiles
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_len  = 800;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 29;
          stall_pct = 29;
        end
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        // occasional noise bytes outside a header start
        if ($urandom_range(7) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_byte(8'($urandom()), 1'b0, 1'($urandom_range(1)));
          end
        end
        r = $urandom_range(99);
        if (r < 64) kind = HK_GOOD;
        else if (r < 70) kind = HK_BAD_MAGIC;
        else if (r < 76) kind = HK_BAD_METHOD;
        else if (r < 86) kind = HK_SHORT;
        else if (r < 93) kind = HK_RESTART;
        else kind = HK_BAD_HCRC;
        send_header(kind);
      end
    end
    in_tvalid <= 1'b0;

    // drain outstanding results, then allow for the pipeline
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.drain_check();

    $display("%0d headers in %0d bytes, %0d results checked, %0d failures",
             headers_sent, bytes_sent, sb.n_checked, sb.n_fail);
    $display("status mix: ok %0d, incomplete %0d, bad magic %0d, bad method %0d, bad crc %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_INCOMPLETE],
             sb.status_seen[ST_BAD_MAGIC], sb.status_seen[ST_BAD_METHOD],
             sb.status_seen[ST_BAD_HCRC]);
    if (sb.n_fail == 0) begin
      $display("PASS gzip_header_parser_core");
    end else begin
      $display("FAIL gzip_header_parser_core");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/gzhp_pkg.sv
rtl/gzip_header_parser_core.sv
dv/gzhp_tb_pkg.sv
dv/tb_top.sv
